### hdl/umod_pkg.sv
// umod_pkg: shared types for the unsigned modulo pipeline.
// Used by umod_cell and unsigned_modulo_64. No dependencies.
package umod_pkg;

    // Control state that travels with each operand pair down the cell row
    typedef struct packed {
        logic valid;     // this stage holds a live transfer
        logic den_zero;  // divisor was zero: the final answer is forced to zero
    } t_stage_ctl;

    localparam t_stage_ctl CTL_IDLE = '{valid: 1'b0, den_zero: 1'b0};

endpackage : umod_pkg

### hdl/umod_cell.sv
// umod_cell: one restoring-division step with its output registers.
// Depends on umod_pkg (t_stage_ctl).
module umod_cell
    import umod_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage_ctl       i_ctl,
    input  logic [WIDTH-1:0] i_part,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output t_stage_ctl       o_ctl,
    output logic [WIDTH-1:0] o_part,
    output logic [WIDTH-1:0] o_num,
    output logic [WIDTH-1:0] o_den
);

    t_stage_ctl       r_ctl;
    logic [WIDTH-1:0] r_part, n_part;
    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_den;

    logic [WIDTH:0]   doubled;
    logic [WIDTH+1:0] diff;

    // Shift in the next dividend bit, subtract the divisor unless it borrows
    always_comb begin
        doubled = {i_part, i_num[WIDTH-1]};
        diff    = {1'b0, doubled} - {2'b00, i_den};
        if (diff[WIDTH+1]) begin
            n_part = doubled[WIDTH-1:0];
        end else begin
            // partial remainder stayed below twice the divisor, so this fits
            n_part = diff[WIDTH-1:0];
        end
    end

    // Control state is reset; payload is not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= CTL_IDLE;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_num  <= {i_num[WIDTH-2:0], 1'b0};
        r_den  <= i_den;
    end

    assign o_ctl  = r_ctl;
    assign o_part = r_part;
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule : umod_cell

### hdl/unsigned_modulo_64.sv
// unsigned_modulo_64: pipelined unsigned remainder, one restoring cell per bit.
// Depends on umod_pkg and umod_cell.
//
// Usage:
//   Input channel: drive i_dividend and i_divisor and raise start. The
//   operand pair transfers at a rising edge where start is high and busy is
//   low. busy is low whenever reset is released, so a new pair may be
//   issued every cycle.
//   Result channel: o_valid is high for one cycle with o_remainder, which
//   is i_dividend mod i_divisor, or zero for a zero divisor.
//   Pipeline: the pair passes through the registers of the row of WIDTH
//   cells in order, each cell handling one dividend bit.
//   Throughput: one operand pair per cycle outside reset, held in flight by
//   the cell row, up to WIDTH pairs at once.
//   Reset: synchronous, active low. All in-flight pairs are dropped and
//   busy is high while reset is asserted.
//   The receiver cannot stall: each result is shown for exactly one cycle.
module unsigned_modulo_64
    import umod_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_remainder
);

    t_stage_ctl       w_ctl  [0:WIDTH];
    logic [WIDTH-1:0] w_part [0:WIDTH];
    logic [WIDTH-1:0] w_num  [0:WIDTH];
    logic [WIDTH-1:0] w_den  [0:WIDTH];

    // Accept every cycle outside reset
    assign busy = ~i_rst_n;

    // Head of the row: fresh partial remainder of zero
    assign w_ctl[0].valid    = start & ~busy;
    assign w_ctl[0].den_zero = (i_divisor == '0);
    assign w_part[0]         = '0;
    assign w_num[0]          = i_dividend;
    assign w_den[0]          = i_divisor;

    // Row of cells, one dividend bit per cell, top bit first
    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        umod_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_part  (w_part[g]),
            .i_num   (w_num[g]),
            .i_den   (w_den[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_part  (w_part[g+1]),
            .o_num   (w_num[g+1]),
            .o_den   (w_den[g+1])
        );
    end

    // Tail of the row: zero divisor forces a zero remainder
    assign o_valid     = w_ctl[WIDTH].valid;
    assign o_remainder = w_ctl[WIDTH].den_zero ? '0 : w_part[WIDTH];

endmodule : unsigned_modulo_64

### hdl/umod_chk.sv
// umod_chk: port-level checks for unsigned_modulo_64, bound to the top level.
// Depends on unsigned_modulo_64 (bind target).
module umod_chk #(
    parameter int WIDTH = 64
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [WIDTH-1:0] i_dividend,
    input logic [WIDTH-1:0] i_divisor,
    input logic             o_valid,
    input logic [WIDTH-1:0] o_remainder
);

    // Never back-pressures outside reset
    a_never_busy: assert property (@(posedge i_clk) i_rst_n |-> !busy)
        else $error("busy raised outside reset");

    // Every transfer yields a result once it has passed through the cell row
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##WIDTH o_valid)
        else $error("missing result after transfer");

    // No result without a matching earlier transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, WIDTH))
        else $error("result without matching transfer");

    // Zero divisor gives a zero remainder
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_divisor == '0)) |-> ##WIDTH (o_remainder == '0))
        else $error("nonzero remainder for zero divisor");

    // Remainder stays below a nonzero divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_divisor != '0))
            |-> ##WIDTH (o_remainder < $past(i_divisor, WIDTH)))
        else $error("remainder not below divisor");

endmodule : umod_chk

bind unsigned_modulo_64 umod_chk #(
    .WIDTH (WIDTH)
) u_umod_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_dividend  (i_dividend),
    .i_divisor   (i_divisor),
    .o_valid     (o_valid),
    .o_remainder (o_remainder)
);

### verif/tb.sv
// tb: self-checking testbench for unsigned_modulo_64 (64-bit remainder pipeline).
// Uses its own restoring-division predictor with a 65-bit partial remainder.
// Needs the package, cell, top level and checker files from hdl.
`timescale 1ns / 100ps

module tb;

    localparam int          DATA_W       = 64;
    localparam int          RESET_CYCLES = 6;
    localparam int          RAND_PER_PH  = 540;
    localparam int          MAX_GAP      = 6;
    localparam longint      LIMIT_CYCLES = 200000;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic [DATA_W-1:0] i_dividend  = '0;
    logic [DATA_W-1:0] i_divisor   = '0;
    logic              busy;
    logic              o_valid;
    logic [DATA_W-1:0] o_remainder;

    logic [DATA_W-1:0] remainder_q[$];
    int                err_count       = 0;
    int                sender_idle_pct = 0;
    longint            cycle_count     = 0;

    unsigned_modulo_64 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_valid     (o_valid),
        .o_remainder (o_remainder)
    );

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Restoring remainder; the extra top bit keeps divisors >= 2^63 exact
    function automatic logic [DATA_W-1:0] restoring_mod(input logic [DATA_W-1:0] num,
                                                        input logic [DATA_W-1:0] den);
        logic [DATA_W:0] part;
        int              bit_idx;
        part = '0;
        if (den == '0)
            return '0;
        for (bit_idx = DATA_W - 1; bit_idx >= 0; bit_idx--) begin
            part = {part[DATA_W-1:0], num[bit_idx]};
            if (part >= {1'b0, den})
                part = part - {1'b0, den};
        end
        return part[DATA_W-1:0];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Prediction on each input transfer, check on each result strobe
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                remainder_q.push_back(restoring_mod(i_dividend, i_divisor));
            if (o_valid) begin
                if (remainder_q.size() == 0) begin
                    $error("remainder: unexpected result %h with nothing pending", o_remainder);
                    err_count++;
                end else begin
                    logic [DATA_W-1:0] exp_rem;
                    exp_rem = remainder_q.pop_front();
                    if (o_remainder !== exp_rem) begin
                        $error("remainder: expected %h, actual %h", exp_rem, o_remainder);
                        err_count++;
                    end
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One operand transfer, with an optional random gap ahead of it
    task automatic issue_pair(input logic [63:0] num, input logic [63:0] den);
        int   gap;
        logic taken;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, MAX_GAP);
            start      <= 1'b0;
            i_dividend <= rand64();
            i_divisor  <= rand64();
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_dividend <= num;
        i_divisor  <= den;
        // busy only moves at edges, so mid-cycle sampling is race free
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Hold off the sender until the pipeline has delivered everything
    task automatic drain_pipeline();
        start <= 1'b0;
        // let the last transfer reach the queue before looking at it
        @(negedge i_clk);
        while (remainder_q.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_extremes();
        issue_pair(64'd0, 64'd1);
        issue_pair(ALL_ONES, 64'd1);
        issue_pair(ALL_ONES, 64'd2);
        issue_pair(ALL_ONES, 64'd3);
        issue_pair(ALL_ONES, ALL_ONES);
        issue_pair(ALL_ONES - 1, ALL_ONES);
        issue_pair(64'd1, ALL_ONES);
        issue_pair(ALL_ONES, ALL_ONES - 1);
        issue_pair(64'd12345, 64'd7);
        issue_pair(64'h0123_4567_89AB_CDEF, 64'h0000_0000_FEDC_BA98);
        issue_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    endtask

    // Zero divisor forces a zero remainder
    task automatic test_zero_divisor();
        issue_pair(64'd0, 64'd0);
        issue_pair(ALL_ONES, 64'd0);
        issue_pair(64'h5555_5555_5555_5555, 64'd0);
    endtask

    // Divisors in the top half need the wide partial remainder
    task automatic test_top_half_divisors();
        issue_pair(ALL_ONES, TOP_BIT);
        issue_pair(TOP_BIT, TOP_BIT + 1);
        issue_pair(ALL_ONES, TOP_BIT + 1);
        issue_pair(TOP_BIT - 1, TOP_BIT);
        issue_pair(TOP_BIT, TOP_BIT);
        issue_pair(64'hFFFF_0000_FFFF_0000, 64'hC000_0000_0000_0001);
        issue_pair(64'hF000_0000_0000_0000, 64'h8000_0000_0000_0003);
        drain_pipeline();
    endtask

    // Random operand pair, shaped toward the interesting corners
    task automatic issue_random_pair();
        logic [63:0] num;
        logic [63:0] den;
        num = rand64();
        case ($urandom_range(9))
            0: den = '0;
            1: den = TOP_BIT | rand64();
            2: den = rand64() >> $urandom_range(48, 63);
            3: begin
                den = rand64();
                num = den >> $urandom_range(0, 8);
            end
            4: begin
                den = rand64() >> 32;
                num = den * ($urandom_range(0, 1000));
            end
            5: begin
                den = rand64() >> $urandom_range(0, 63);
                num = ALL_ONES;
            end
            default: begin
                num = num >> $urandom_range(0, 63);
                den = rand64() >> $urandom_range(0, 63);
            end
        endcase
        issue_pair(num, den);
    endtask

    task automatic test_random(input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int n = 0; n < RAND_PER_PH; n++) begin
            issue_random_pair();
            if (n % 200 == 199)
                drain_pipeline();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_zero_divisor();
        test_top_half_divisors();
        test_random(33);
        test_random(74);
        test_random(0);

        // Flush: wait for all results, then let the pipeline run empty before reporting
        start <= 1'b0;
        while (remainder_q.size() != 0)
            @(negedge i_clk);
        repeat (DATA_W + 8) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
hdl/umod_pkg.sv
hdl/umod_cell.sv
hdl/unsigned_modulo_64.sv
hdl/umod_chk.sv
verif/tb.sv
